>>> hdl/base41_byte_encoder_defines.svh
// Assertion macros shared by the base-41 encoder modules.
`ifndef BASE41_BYTE_ENCODER_DEFINES_SVH
`define BASE41_BYTE_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define B41_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define B41_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define B41_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define B41_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/b41enc_pkg.sv
// Package with types, constants and the alphabet lookup of the base-41 encoder.
`timescale 1ns / 1ps
package b41enc_pkg;

    localparam int B41_QUEUE_DEPTH = 2;

    localparam logic [5:0]  B41_RADIX          = 6'd41;
    localparam logic [15:0] B41_BYTE_BASE      = 16'd256;
    localparam logic [15:0] B41_TWO_DIGIT_LIM  = 16'd1681;
    localparam logic [16:0] B41_RECIP          = 17'd102301;
    localparam int          B41_RECIP_SHIFT    = 22;

    localparam logic [1:0]  B41_CNT_ONE   = 2'd1;
    localparam logic [1:0]  B41_CNT_TWO   = 2'd2;
    localparam logic [1:0]  B41_CNT_THREE = 2'd3;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  count;
        logic        last;
    } job_t;

    function automatic logic [6:0] b41_char(input logic [5:0] digit);
        logic [6:0] code;
        code = 7'd0;
        case (digit) inside
            [6'd0:6'd9]:   code = 7'd48 + {1'b0, digit};
            [6'd10:6'd35]: code = 7'd55 + {1'b0, digit};
            6'd36:         code = 7'd32;
            6'd37:         code = 7'd43;
            6'd38:         code = 7'd45;
            6'd39:         code = 7'd46;
            6'd40:         code = 7'd47;
            default:       code = 7'd0;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/b41enc_if.sv
// Valid/ready channel interfaces for the byte input and the character output.
`timescale 1ns / 1ps
interface b41enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b41enc_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> hdl/b41enc_front.sv
// Front end: pairs incoming bytes and classifies each pair into an encode job.
`timescale 1ns / 1ps
module b41enc_front
    import b41enc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b41enc_byte_if.sink  in_bytes,
    output logic         job_valid,
    input  logic         job_ready,
    output job_t         job
);

    logic [7:0]  held_byte_reg;
    logic [7:0]  held_byte_next;
    logic        pending_reg;
    logic        pending_next;
    logic        accept;
    logic [15:0] pair_value;
    logic        two_digit;

    assign in_bytes.ready = job_ready;
    assign accept         = in_bytes.valid && in_bytes.ready;
    assign job_valid      = in_bytes.valid && (pending_reg || in_bytes.last_byte);

    assign pair_value = {in_bytes.data_byte, held_byte_reg};
    assign two_digit  = (pair_value >= B41_BYTE_BASE) && (pair_value < B41_TWO_DIGIT_LIM);

    always_comb
    begin
        job.last = in_bytes.last_byte;
        if (pending_reg)
        begin
            job.value = pair_value;
            job.count = (in_bytes.last_byte && two_digit) ? B41_CNT_TWO : B41_CNT_THREE;
        end
        else
        begin
            job.value = {8'd0, in_bytes.data_byte};
            job.count = (in_bytes.data_byte >= {2'b00, B41_RADIX}) ? B41_CNT_TWO : B41_CNT_ONE;
        end
    end

    always_comb
    begin
        held_byte_next = held_byte_reg;
        pending_next   = pending_reg;
        if (accept)
        begin
            if (!pending_reg && !in_bytes.last_byte)
            begin
                held_byte_next = in_bytes.data_byte;
                pending_next   = 1'b1;
            end
            else
            begin
                held_byte_next = 8'd0;
                pending_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg <= 8'd0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            held_byte_reg <= held_byte_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

>>> hdl/b41enc_queue.sv
// Short job queue between the front end and the digit back end.
`timescale 1ns / 1ps
`include "base41_byte_encoder_defines.svh"
module b41enc_queue
    import b41enc_pkg::*;
#(
    parameter int DEPTH = B41_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B41_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= FULL_CNT)
    `B41_ASSERT_NXT(a_push_only_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> hdl/b41enc_back.sv
// Back end: peels base-41 digits off each job, one character per cycle while out_chars is ready.
`timescale 1ns / 1ps
`include "base41_byte_encoder_defines.svh"
module b41enc_back
    import b41enc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  job_t           job,
    b41enc_char_if.source  out_chars
);

    logic        busy_reg;
    logic        busy_next;
    logic [15:0] value_reg;
    logic [15:0] value_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        last_reg;
    logic        last_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  char_reg;
    logic [6:0]  char_next;
    logic        last_char_reg;
    logic        last_char_next;

    logic        step_valid;
    logic        can_load;
    logic        step;
    logic [15:0] src_value;
    logic [1:0]  src_count;
    logic        src_last;
    logic [32:0] product;
    logic [10:0] quotient;
    logic [15:0] quot_times_radix;
    logic [15:0] remainder;
    logic        final_digit;

    assign step_valid = busy_reg || job_valid;
    assign can_load   = !out_valid_reg || out_chars.ready;
    assign step       = step_valid && can_load;
    assign job_ready  = !busy_reg && can_load;

    assign src_value = busy_reg ? value_reg : job.value;
    assign src_count = busy_reg ? count_reg : job.count;
    assign src_last  = busy_reg ? last_reg  : job.last;

    assign product          = src_value * B41_RECIP;
    assign quotient         = product[B41_RECIP_SHIFT +: 11];
    assign quot_times_radix = {quotient, 5'd0} + {2'b00, quotient, 3'd0} + {5'd0, quotient};
    assign remainder        = src_value - quot_times_radix;
    assign final_digit      = (src_count == B41_CNT_ONE);

    always_comb
    begin
        busy_next      = busy_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_char_next = last_char_reg;
        if (out_valid_reg && out_chars.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            char_next      = b41_char(remainder[5:0]);
            last_char_next = src_last && final_digit;
            busy_next      = !final_digit;
            value_next     = {5'd0, quotient};
            count_next     = src_count - 2'd1;
            last_next      = src_last;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        char_reg      <= char_next;
        last_char_reg <= last_char_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_chars.valid     = out_valid_reg;
    assign out_chars.char_code = char_reg;
    assign out_chars.last_char = last_char_reg;

    `B41_ASSERT_IMP(a_busy_has_digits, clk, rst_n, busy_reg, count_reg == B41_CNT_ONE || count_reg == B41_CNT_TWO)
    `B41_ASSERT_NXT(a_step_fills_output, clk, rst_n, step, out_valid_reg)
    `B41_ASSERT_IMP(a_digit_in_range, clk, rst_n, step, remainder < {10'd0, B41_RADIX})

endmodule

>>> hdl/base41_byte_encoder.sv
// Top level of the base-41 byte encoder.
//
// in_bytes is a valid/ready byte channel (data_byte, last_byte); a transfer
// takes one byte. out_chars is a valid/ready character channel (char_code,
// last_char); a transfer delivers one ASCII character of the base-41 text.
// The first byte of a pair is held; the second byte, or a lone final byte,
// becomes a job of one to three digits in a short queue. The back end emits
// one character per cycle from that queue while out_chars is ready, least
// significant digit first, dividing by 41 with a reciprocal multiply per digit.
// A pair-completing byte is written into a queue slot; its first character
// is then registered in the back end's output register and shown on out_chars.
// Throughput is one character per cycle while out_chars is ready, and a pair
// of bytes yields up to three characters; the single digit unit in the back end sets the throughput.
// When the receiver stalls, the output register holds its character, the
// back end stops, the queue fills and then in_bytes.ready drops.
// Reset clears the held byte, the queue and the output valid flag; nothing
// is in flight afterwards and the next byte starts a new message.
`timescale 1ns / 1ps
module base41_byte_encoder
    import b41enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = B41_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    b41enc_byte_if.sink   in_bytes,
    b41enc_char_if.source out_chars
);

    logic front_valid;
    logic front_ready;
    job_t front_job;
    logic back_valid;
    logic back_ready;
    job_t back_job;

    b41enc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_bytes  (in_bytes),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    b41enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_job    (back_job)
    );

    b41enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .out_chars (out_chars)
    );

endmodule

>>> verif/base41_encoder_checker.sv
`timescale 1ns / 1ps
// Scoreboard that predicts the base-41 characters of every byte transfer and checks the output.
module base41_encoder_checker
(
    input  logic          clk,
    input  logic          rst_n,
    b41enc_byte_if        in_mon,
    b41enc_char_if        out_mon,
    output int            fail_count,
    output int            expected_left
);

    localparam int unsigned RADIX        = 41;
    localparam int unsigned BYTE_BASE    = 256;
    localparam int unsigned TWO_CHAR_TOP = 41 * 41;
    localparam logic [8*41-1:0] ALPHABET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ +-./";

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    text_char_t  char_queue[$];
    logic [7:0]  pair_low;
    logic        low_held;
    int          errors;

    assign fail_count = errors;

    initial
    begin
        errors        = 0;
        pair_low      = 8'd0;
        low_held      = 1'b0;
        expected_left = 0;
    end

    function automatic logic [6:0] digit_ascii(input int unsigned digit);
        logic [7:0] code;
        code = ALPHABET[8 * (40 - digit) +: 8];
        return code[6:0];
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic predict_chars(input logic [7:0] data, input logic final_byte);
        int unsigned word;
        int          n_chars;
        text_char_t  item;
        if (!low_held && !final_byte)
        begin
            pair_low = data;
            low_held = 1'b1;
        end
        else
        begin
            if (!low_held)
            begin
                word    = data;
                n_chars = (word >= RADIX) ? 2 : 1;
            end
            else
            begin
                word    = pair_low + data * BYTE_BASE;
                n_chars = (final_byte && word >= BYTE_BASE && word < TWO_CHAR_TOP) ? 2 : 3;
            end
            for (int k = 0; k < n_chars; k++)
            begin
                item.code = digit_ascii(word % RADIX);
                item.last = final_byte && (k == n_chars - 1);
                char_queue = {char_queue, item};
                word = word / RADIX;
            end
            pair_low = 8'd0;
            low_held = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            char_queue.delete();
            pair_low      = 8'd0;
            low_held      = 1'b0;
            expected_left <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (char_queue.size() == 0)
                    flag_mismatch("unexpected character", out_mon.char_code, -1);
                else
                begin
                    want = char_queue.pop_front();
                    if (out_mon.char_code !== want.code)
                        flag_mismatch("char_code", out_mon.char_code, want.code);
                    if (out_mon.last_char !== want.last)
                        flag_mismatch("last_char", out_mon.last_char, want.last);
                end
            end
            if (in_mon.valid && in_mon.ready)
                predict_chars(in_mon.data_byte, in_mon.last_byte);
            expected_left <= char_queue.size();
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the base-41 encoder testbench: clock, reset, byte stimulus, watchdog and verdict.
module testbench;

    localparam int RANDOM_ITEMS = 350;
    localparam int STALL_LIMIT  = 2000;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   idle_cycles;
    int   mismatches;
    int   outstanding;

    b41enc_byte_if in_bytes();
    b41enc_char_if out_chars();

    base41_byte_encoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_bytes  (in_bytes),
        .out_chars (out_chars)
    );

    base41_encoder_checker scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_mon        (in_bytes),
        .out_mon       (out_chars),
        .fail_count    (mismatches),
        .expected_left (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_chars.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_chars.ready <= no_idle || ($urandom_range(99) >= 29);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_bytes.valid && in_bytes.ready) || (out_chars.valid && out_chars.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic final_byte);
        while (!no_idle && $urandom_range(99) < 29)
        begin
            in_bytes.valid <= 1'b0;
            @(posedge clk);
        end
        in_bytes.valid     <= 1'b1;
        in_bytes.data_byte <= data;
        in_bytes.last_byte <= final_byte;
        @(posedge clk);
        while (!in_bytes.ready)
            @(posedge clk);
    endtask

    // hold off the sender until every predicted character has been transferred
    task automatic drain_results(input int settle);
        in_bytes.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    initial
    begin
        int         sent;
        int         msg_len;
        logic [7:0] value;
        logic       paused;
        rst_n              = 1'b0;
        no_idle            = 1'b0;
        in_bytes.valid     = 1'b0;
        in_bytes.data_byte = 8'd0;
        in_bytes.last_byte = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'd0, 1'b1);
        send_byte(8'd40, 1'b1);
        send_byte(8'd41, 1'b1);
        send_byte(8'd255, 1'b1);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b1);
        send_byte(8'd255, 1'b0);
        send_byte(8'd0, 1'b1);
        send_byte(8'd0, 1'b0);
        send_byte(8'd1, 1'b1);
        send_byte(8'h90, 1'b0);
        send_byte(8'h06, 1'b1);
        send_byte(8'h91, 1'b0);
        send_byte(8'h06, 1'b1);
        send_byte(8'd255, 1'b0);
        send_byte(8'd255, 1'b1);
        send_byte(8'd0, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(8'd5, 1'b1);
        drain_results(4);

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            msg_len = $urandom_range(1, 8);
            for (int i = 0; i < msg_len; i++)
            begin
                if ($urandom_range(99) < 20)
                begin
                    case ($urandom_range(7))
                        0:       value = 8'h00;
                        1:       value = 8'h01;
                        2:       value = 8'h05;
                        3:       value = 8'h06;
                        4:       value = 8'h07;
                        5:       value = 8'h90;
                        6:       value = 8'h91;
                        default: value = 8'hFF;
                    endcase
                end
                else
                    value = 8'($urandom_range(255));
                no_idle <= (sent >= 150 && sent < 230);
                send_byte(value, i == msg_len - 1);
                sent++;
            end
            if (!paused && sent >= 300)
            begin
                paused = 1'b1;
                drain_results(4);
            end
        end

        drain_results(8);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
